// ===== rtl/utf8_to_latin1_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder assertion macros
// Shared property macros for the decoder's port-level checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_LATIN1_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_LATIN1_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define U8L1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder port check failed");

// Next-cycle implication, disabled while reset is active.
`define U8L1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder port check failed");

`endif

// ===== rtl/u8l1_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder package
// Command type passed from the byte classifier to the character assembler.
// ----------------------------------------------------------------------------
package u8l1_pkg;

    localparam logic [7:0] REPL_RESET = 8'h3F;
    localparam logic [1:0] CONT_TAG   = 2'b10;
    localparam logic [2:0] STRAY_LEFT = 3'd4;

    typedef struct packed {
        logic       is_cont;
        logic [6:0] val;
        logic [2:0] left;
        logic       last;
    } cmd_t;

endpackage

// ===== rtl/u8l1_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder front end
// Classifies each incoming byte and pushes a command into the queue.
// ----------------------------------------------------------------------------
module u8l1_front
    import u8l1_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       full,
    output logic       push,
    output cmd_t       push_cmd
);

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_cmd.is_cont = (in_byte[7:6] == CONT_TAG);
        push_cmd.last    = in_last;
        unique case (in_byte) inside
            [8'h00:8'h7F]:
            begin
                push_cmd.val  = in_byte[6:0];
                push_cmd.left = 3'd0;
            end
            [8'h80:8'hBF]:
            begin
                push_cmd.val  = {1'b0, in_byte[5:0]};
                push_cmd.left = STRAY_LEFT;
            end
            [8'hC0:8'hDF]:
            begin
                push_cmd.val  = {2'b0, in_byte[4:0]};
                push_cmd.left = 3'd1;
            end
            [8'hE0:8'hEF]:
            begin
                push_cmd.val  = {3'b0, in_byte[3:0]};
                push_cmd.left = 3'd2;
            end
            [8'hF0:8'hF7]:
            begin
                push_cmd.val  = {4'b0, in_byte[2:0]};
                push_cmd.left = 3'd3;
            end
            [8'hF8:8'hFB]:
            begin
                push_cmd.val  = {5'b0, in_byte[1:0]};
                push_cmd.left = 3'd4;
            end
            default:
            begin
                push_cmd.val  = {6'b0, in_byte[0]};
                push_cmd.left = 3'd5;
            end
        endcase
    end

endmodule

// ===== rtl/u8l1_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder command queue
// Small first-in first-out buffer between the classifier and the assembler.
// ----------------------------------------------------------------------------
module u8l1_queue
    import u8l1_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/u8l1_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder back end
// Assembles code points from queued commands and drives the result register.
// ----------------------------------------------------------------------------
module u8l1_back
    import u8l1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [7:0] replacement_char,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_replaced,
    output logic       out_last
);

    logic [7:0] repl_reg;
    logic       active_reg;
    logic       active_next;
    logic [2:0] left_reg;
    logic [2:0] left_next;
    logic [7:0] low_reg;
    logic [7:0] low_next;
    logic       big_reg;
    logic       big_next;
    logic       phase_reg;
    logic       phase_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_replaced_reg;
    logic       out_last_reg;

    logic       cont_path;
    logic [7:0] sh_low;
    logic       sh_big;
    logic [2:0] left_dec;
    logic       a_en;
    logic [7:0] a_low;
    logic       a_big;
    logic       a_last;
    logic       b_en;
    logic       can_emit;
    logic       emit;
    logic       sel_b;
    logic [7:0] res_low;
    logic       res_big;
    logic       res_last;

    assign cont_path = active_reg && head_cmd.is_cont;
    assign sh_low    = {low_reg[1:0], head_cmd.val[5:0]};
    assign sh_big    = big_reg || (low_reg[7:2] != 6'd0);
    assign left_dec  = left_reg - 3'd1;
    assign can_emit  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cont_path)
        begin
            a_en   = (left_dec == 3'd0) || head_cmd.last;
            a_low  = sh_low;
            a_big  = sh_big;
            a_last = head_cmd.last;
            b_en   = 1'b0;
        end
        else
        begin
            a_en   = active_reg;
            a_low  = low_reg;
            a_big  = big_reg;
            a_last = 1'b0;
            b_en   = (head_cmd.left == 3'd0) || head_cmd.last;
        end
    end

    always_comb
    begin
        emit       = 1'b0;
        sel_b      = 1'b0;
        pop        = 1'b0;
        phase_next = phase_reg;
        if (head_valid)
        begin
            if (phase_reg)
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    sel_b      = 1'b1;
                    pop        = 1'b1;
                    phase_next = 1'b0;
                end
            end
            else if (a_en)
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (b_en)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            else if (b_en)
            begin
                if (can_emit)
                begin
                    emit  = 1'b1;
                    sel_b = 1'b1;
                    pop   = 1'b1;
                end
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        left_next   = left_reg;
        low_next    = low_reg;
        big_next    = big_reg;
        if (pop)
        begin
            if (cont_path)
            begin
                active_next = !a_en;
                left_next   = left_dec;
                low_next    = sh_low;
                big_next    = sh_big;
            end
            else
            begin
                active_next = !b_en;
                left_next   = head_cmd.left;
                low_next    = {1'b0, head_cmd.val};
                big_next    = 1'b0;
            end
        end
    end

    assign res_low  = sel_b ? {1'b0, head_cmd.val} : a_low;
    assign res_big  = sel_b ? 1'b0 : a_big;
    assign res_last = sel_b ? head_cmd.last : a_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg      <= REPL_RESET;
            active_reg    <= 1'b0;
            left_reg      <= '0;
            low_reg       <= '0;
            big_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                repl_reg <= replacement_char;
            end
            active_reg <= active_next;
            left_reg   <= left_next;
            low_reg    <= low_next;
            big_reg    <= big_next;
            phase_reg  <= phase_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg     <= res_big ? repl_reg : res_low;
            out_replaced_reg <= res_big;
            out_last_reg     <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_replaced = out_replaced_reg;
    assign out_last     = out_last_reg;

endmodule

// ===== rtl/utf8_to_latin1_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder
// Converts a line of UTF-8 bytes into Latin-1 bytes, one character at a time.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    in_byte, in_last
//  out      out_valid / out_stall  out_byte, out_replaced, out_last
//  cfg      cfg_valid / cfg_ready  replacement_char
//
// One byte is taken per cycle unless the queue is full. A byte that closes
// a pending character and also yields one of its own makes the assembler
// emit the pending character first, then its own. Results are registered.
// The command queue holds FIFO_DEPTH bytes, so each side may stall alone.
// Reset clears all control state and sets the replacement byte to 0x3F.
// ----------------------------------------------------------------------------
module utf8_to_latin1_decoder_top
    import u8l1_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] replacement_char,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_replaced,
    output logic       out_last
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;

    u8l1_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    u8l1_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    u8l1_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid && cfg_ready),
        .replacement_char (replacement_char),
        .head_valid       (head_valid),
        .head_cmd         (head_cmd),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .out_replaced     (out_replaced),
        .out_last         (out_last)
    );

endmodule

// ===== rtl/u8l1_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder port checker
// Watches the decoder's ports and checks ordering of lines and results.
// ----------------------------------------------------------------------------
`include "utf8_to_latin1_decoder_top_assert.svh"

module u8l1_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_replaced,
    input logic       out_last
);

    logic [15:0] open_reg;
    logic [15:0] open_next;
    logic        seen_reg;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        open_next = open_reg;
        if (in_xfer && in_last && !(out_xfer && out_last))
        begin
            open_next = open_reg + 16'd1;
        end
        else if (!(in_xfer && in_last) && out_xfer && out_last)
        begin
            open_next = open_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            if (in_xfer)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    // A result held back by the receiver stays in place.
    `U8L1_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(out_replaced) && $stable(out_last))

    // A line end on the output needs a line end taken on the input.
    `U8L1_ASSERT_IMPL(a_last_has_line, clk, rst_n, out_valid && out_last, open_reg != 16'd0)

    // No result appears before any byte was taken.
    `U8L1_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, seen_reg)

endmodule

bind utf8_to_latin1_decoder_top u8l1_checker u_checker (.*);

// ===== tb/utf8_to_latin1_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 decoder testbench
// Drives the decoder with a short table of directed bytes and then with lines
// of random UTF-8 sequences, some of them truncated or broken. A behavioral
// decoder inside the testbench predicts the output bytes that the table does
// not give, and each output transfer is compared with the oldest prediction.
// The run goes through several replacement bytes and several patterns of
// sender idling and receiver stalling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_latin1_decoder_top_tb;
    import u8l1_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       last;
    } l1_char_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_in_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        int         typed;
        l1_char_t   c0;
        l1_char_t   c1;
    } dir_row_t;

    localparam int       PREDICT    = -1;
    localparam int       DIR_ROWS   = 26;
    localparam int       PHASES     = 6;
    localparam int       PHASE_ITEMS = 258;
    localparam int       SETTLE     = 16;
    localparam int       HOLD_CYCLES = 120;
    localparam l1_char_t NO_CHAR    = '0;

    localparam int SEND_PCT [PHASES] = '{0, 45, 0, 35, 0, 20};
    localparam int STALL_PCT [PHASES] = '{0, 0, 45, 35, 10, 20};
    localparam logic [7:0] REPL_VALS [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h3F};

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1, '{8'h00, 1'b0, 1'b0}, NO_CHAR},
        '{8'h7F, 1'b1, 1, '{8'h7F, 1'b0, 1'b1}, NO_CHAR},
        '{8'hC3, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'hA9, 1'b0, 1, '{8'hE9, 1'b0, 1'b0}, NO_CHAR},
        '{8'hE2, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'h82, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'hAC, 1'b0, 1, '{8'h3F, 1'b1, 1'b0}, NO_CHAR},
        '{8'hF0, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'h9F, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'h98, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'h80, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hFC, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'h80, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'h41, 1'b0, 2, '{8'h00, 1'b0, 1'b0}, '{8'h41, 1'b0, 1'b0}},
        '{8'hC3, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'h42, 1'b1, 2, '{8'h03, 1'b0, 1'b0}, '{8'h42, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1, '{8'h01, 1'b0, 1'b1}, NO_CHAR},
        '{8'hF8, 1'b0, PREDICT, NO_CHAR, NO_CHAR},
        '{8'h80, 1'b1, PREDICT, NO_CHAR, NO_CHAR},
        '{8'hC2, 1'b0, 0, NO_CHAR, NO_CHAR},
        '{8'hBF, 1'b1, 1, '{8'hBF, 1'b0, 1'b1}, NO_CHAR}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] replacement_char = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_replaced;
    logic       out_last;

    logic [30:0] code_acc = '0;
    logic [2:0]  conts_due = '0;
    logic        char_open = 1'b0;
    logic [7:0]  subst_byte = REPL_RESET;

    l1_char_t expected_chars [$];
    utf8_in_t line_bytes [$];
    int       err_cnt = 0;
    int       send_pct = 0;
    int       stall_pct = 0;
    int       hold_left = 0;

    utf8_to_latin1_decoder_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .replacement_char (replacement_char),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .in_last          (in_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .out_replaced     (out_replaced),
        .out_last         (out_last)
    );

    always #1 clk = ~clk;

    initial
    begin
        #500000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic l1_char_t close_char();
        l1_char_t c;
        if (code_acc <= 31'h0FF)
            c = '{code_acc[7:0], 1'b0, 1'b0};
        else
            c = '{subst_byte, 1'b1, 1'b0};
        code_acc  = '0;
        conts_due = '0;
        char_open = 1'b0;
        return c;
    endfunction

    function automatic void decode_utf8_byte(input logic [7:0] b, input logic l,
                                             output int n, output l1_char_t c0,
                                             output l1_char_t c1);
        l1_char_t got [2];
        n = 0;
        got[0] = NO_CHAR;
        got[1] = NO_CHAR;
        if (char_open && conts_due != 0 && b[7:6] == CONT_TAG)
        begin
            code_acc  = {code_acc[24:0], b[5:0]};
            conts_due = conts_due - 3'd1;
            if (conts_due == 0)
                got[n++] = close_char();
        end
        else
        begin
            if (char_open)
                got[n++] = close_char();
            char_open = 1'b1;
            if (!b[7])
            begin
                code_acc = {24'd0, b[6:0]};
                got[n++] = close_char();
            end
            else if (b[7:6] == CONT_TAG)
            begin
                code_acc  = {25'd0, b[5:0]};
                conts_due = STRAY_LEFT;
            end
            else if (!b[5])
            begin
                code_acc  = {26'd0, b[4:0]};
                conts_due = 3'd1;
            end
            else if (!b[4])
            begin
                code_acc  = {27'd0, b[3:0]};
                conts_due = 3'd2;
            end
            else if (!b[3])
            begin
                code_acc  = {28'd0, b[2:0]};
                conts_due = 3'd3;
            end
            else if (!b[2])
            begin
                code_acc  = {29'd0, b[1:0]};
                conts_due = 3'd4;
            end
            else
            begin
                code_acc  = {30'd0, b[0]};
                conts_due = 3'd5;
            end
        end
        if (l)
        begin
            if (char_open)
                got[n++] = close_char();
            if (n > 0)
                got[n - 1].last = 1'b1;
        end
        c0 = got[0];
        c1 = got[1];
    endfunction

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_output
        l1_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                report($sformatf("unexpected output byte %02h", out_byte));
            else
            begin
                want = expected_chars.pop_front();
                if (out_byte !== want.data)
                    report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
                if (out_replaced !== want.replaced)
                    report($sformatf("out_replaced %b, want %b", out_replaced,
                                     want.replaced));
                if (out_last !== want.last)
                    report($sformatf("out_last %b, want %b", out_last, want.last));
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic l, input int typed,
                            input l1_char_t t0, input l1_char_t t1);
        int       n;
        l1_char_t c0;
        l1_char_t c1;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        in_last  = l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_utf8_byte(b, l, n, c0, c1);
        if (typed != PREDICT)
        begin
            n  = typed;
            c0 = t0;
            c1 = t1;
        end
        if (n > 0)
            expected_chars.push_back(c0);
        if (n > 1)
            expected_chars.push_back(c1);
        @(negedge clk);
    endtask

    task automatic write_repl(input logic [7:0] v);
        cfg_valid        = 1'b1;
        replacement_char = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        subst_byte = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic gen_line();
        logic [7:0] line_q [$];
        logic [7:0] lead;
        int         kind;
        int         conts;
        repeat ($urandom_range(1, 8))
        begin
            kind  = $urandom_range(0, 99);
            conts = 0;
            if (kind < 30)
                lead = 8'($urandom_range(0, 127));
            else if (kind < 50)
            begin
                if ($urandom_range(0, 1) == 1)
                    lead = 8'hC0 | 8'($urandom_range(0, 3));
                else
                    lead = 8'hC0 | 8'($urandom_range(0, 31));
                conts = 1;
            end
            else if (kind < 63)
            begin
                lead  = 8'hE0 | 8'($urandom_range(0, 15));
                conts = 2;
            end
            else if (kind < 71)
            begin
                lead  = 8'hF0 | 8'($urandom_range(0, 7));
                conts = 3;
            end
            else if (kind < 77)
            begin
                lead  = 8'hF8 | 8'($urandom_range(0, 3));
                conts = 4;
            end
            else if (kind < 83)
            begin
                lead  = 8'hFC | 8'($urandom_range(0, 1));
                conts = 5;
            end
            else if (kind < 89)
            begin
                lead  = 8'h80 | 8'($urandom_range(0, 63));
                conts = $urandom_range(0, STRAY_LEFT);
            end
            else if (kind < 95)
            begin
                lead  = 8'hC0 | 8'($urandom_range(0, 63));
                conts = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 :
                        (lead < 8'hF8) ? 3 : (lead < 8'hFC) ? 4 : 5;
                conts = $urandom_range(0, conts - 1);
            end
            else
                lead = 8'($urandom_range(0, 255));
            line_q.push_back(lead);
            repeat (conts) line_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        foreach (line_q[i])
            line_bytes.push_back('{line_q[i], i == line_q.size() - 1});
    endtask

    initial
    begin
        utf8_in_t item;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            put_byte(DIR_TAB[i].data, DIR_TAB[i].last, DIR_TAB[i].typed,
                     DIR_TAB[i].c0, DIR_TAB[i].c1);
        in_valid = 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            send_pct  = SEND_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == 2 || p == 4)
                write_repl(8'($urandom_range(1, 254)));
            else
                write_repl(REPL_VALS[p]);
            if (p == 4)
                hold_left = HOLD_CYCLES;
            while (line_bytes.size() < PHASE_ITEMS)
                gen_line();
            while (line_bytes.size() != 0)
            begin
                item = line_bytes.pop_front();
                put_byte(item.data, item.last, PREDICT, NO_CHAR, NO_CHAR);
            end
            in_valid = 1'b0;
            drain();
        end

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
